/* design/slt_pkg.sv */
// Shared types and constants for the label table.
package slt_pkg;

  localparam int CHAR_W   = 8;
  localparam int LEN_W    = 7;
  localparam int ADDR_W   = 16;
  localparam int STATUS_W = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_TOO_LONG  = 3'd4
  } status_t;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // One finished name, handed from the front to the back.
  typedef struct packed {
    logic              kind;
    logic [LEN_W-1:0]  len;
    logic              overflow;
    logic [ADDR_W-1:0] addr;
    logic              bank;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_COPY,
    BK_COPY_END,
    BK_META,
    BK_CHK,
    BK_CMP,
    BK_NEXT,
    BK_DONE
  } back_state_t;

endpackage

/* design/slt_if.sv */
// Valid/ready channel interfaces for character beats and result beats.
interface slt_req_if import slt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;
  logic [ADDR_W-1:0] label_address;

  modport source (output valid, kind, char_code, last_char, label_address, input ready);
  modport sink   (input valid, kind, char_code, last_char, label_address, output ready);
endinterface

interface slt_rsp_if import slt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   found_address;

  modport source (output valid, status, found_address, input ready);
  modport sink   (input valid, status, found_address, output ready);
endinterface

/* design/slt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module slt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/slt_front.sv */
// Front end: collects name characters into a ping-pong buffer and issues commands.
module slt_front import slt_pkg::*; #(
  parameter int MAX_NAME_CHARS = 80,
  localparam int BAW = $clog2(2 * MAX_NAME_CHARS)
) (
  input  logic              clk,
  input  logic              rst,
  slt_req_if.sink           req,
  input  logic              bank_free,
  output logic              nb_we,
  output logic [BAW-1:0]    nb_waddr,
  output logic [CHAR_W-1:0] nb_wdata,
  output logic              push,
  output cmd_t              push_cmd
);

  logic [LEN_W-1:0] len;
  logic             ovf;
  logic             bank;
  logic [1:0]       pending;
  logic             accept;
  logic             room;
  logic [BAW-1:0]   bank_off;

  // Both banks busy means the back still needs them; hold off new characters.
  assign req.ready = (pending < 2'd2);
  assign accept    = req.valid && req.ready;
  assign room      = (len < LEN_W'(MAX_NAME_CHARS));
  assign bank_off  = bank ? BAW'(MAX_NAME_CHARS) : '0;

  assign nb_we    = accept && room;
  assign nb_waddr = BAW'(bank_off + BAW'(len));
  assign nb_wdata = req.char_code;

  assign push              = accept && req.last_char;
  assign push_cmd.kind     = req.kind;
  assign push_cmd.len      = room ? LEN_W'(len + LEN_W'(1)) : len;
  assign push_cmd.overflow = ovf || !room;
  assign push_cmd.addr     = req.label_address;
  assign push_cmd.bank     = bank;

  always_ff @(posedge clk) begin
    if (rst) begin
      len     <= '0;
      ovf     <= 1'b0;
      bank    <= 1'b0;
      pending <= '0;
    end else begin
      if (accept) begin
        if (req.last_char) begin
          len  <= '0;
          ovf  <= 1'b0;
          bank <= ~bank;
        end else if (room) begin
          len <= LEN_W'(len + LEN_W'(1));
        end else begin
          ovf <= 1'b1;
        end
      end
      case ({push, bank_free})
        2'b10:   pending <= pending + 2'd1;
        2'b01:   pending <= pending - 2'd1;
        default: pending <= pending;
      endcase
    end
  end

  a_pending_bound: assert property (@(posedge clk) disable iff (rst) pending <= 2'd2)
    else $error("front: more names pending than buffer banks");
  a_free_has_owner: assert property (@(posedge clk) disable iff (rst)
    bank_free |-> pending != 2'd0)
    else $error("front: bank released with no name pending");

endmodule

/* design/slt_queue.sv */
// Two-entry command queue between the front and back ends.
module slt_queue import slt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic pop_valid,
  output cmd_t pop_cmd
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign pop_valid = (fill != 2'd0);
  assign pop_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* design/slt_back.sv */
// Back end: stores inserted names and walks the table for lookups.
module slt_back import slt_pkg::*; #(
  parameter int MAX_ENTRIES    = 256,
  parameter int MAX_NAME_CHARS = 80,
  localparam int BAW = $clog2(2 * MAX_NAME_CHARS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  cmd_t              q_cmd,
  output logic              pop,
  output logic [BAW-1:0]    nb_raddr,
  input  logic [CHAR_W-1:0] nb_rdata,
  output logic              bank_free,
  slt_rsp_if.source         rsp
);

  localparam int ND  = MAX_ENTRIES * MAX_NAME_CHARS;
  localparam int NAW = (ND > 1) ? $clog2(ND) : 1;
  localparam int EW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int MW  = LEN_W + ADDR_W;

  back_state_t         state, state_next;
  cmd_t                cmd, cmd_next;
  logic [CW-1:0]       count, count_next;
  logic [NAW-1:0]      base_w, base_w_next;
  logic [EW-1:0]       ent, ent_next;
  logic [NAW-1:0]      ent_base, ent_base_next;
  logic [LEN_W-1:0]    idx, idx_next;
  logic [LEN_W-1:0]    cmp_i, cmp_i_next;
  logic [LEN_W-1:0]    cp_i, cp_i_next;
  logic                cp_v, cp_v_next;
  logic [ADDR_W-1:0]   hit, hit_next;
  status_t             res_st, res_st_next;
  logic [ADDR_W-1:0]   res_addr, res_addr_next;
  logic                out_valid, out_valid_next;
  status_t             out_status, out_status_next;
  logic [ADDR_W-1:0]   out_addr, out_addr_next;

  logic                meta_we;
  logic [MW-1:0]       meta_rdata;
  logic [CHAR_W-1:0]   nm_rdata;
  logic [BAW-1:0]      bank_off;
  logic [LEN_W-1:0]    last_idx;

  assign bank_off = cmd.bank ? BAW'(MAX_NAME_CHARS) : '0;
  assign nb_raddr = BAW'(bank_off + BAW'(idx));
  assign last_idx = LEN_W'(cmd.len - LEN_W'(1));

  slt_ram #(.WIDTH(CHAR_W), .DEPTH(ND)) u_names (
    .clk   (clk),
    .we    (cp_v),
    .waddr (NAW'(base_w + NAW'(cp_i))),
    .wdata (nb_rdata),
    .raddr (NAW'(ent_base + NAW'(idx))),
    .rdata (nm_rdata)
  );

  slt_ram #(.WIDTH(MW), .DEPTH(MAX_ENTRIES)) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (count[EW-1:0]),
    .wdata ({cmd.len, cmd.addr}),
    .raddr (ent),
    .rdata (meta_rdata)
  );

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.found_address = out_addr;

  always_comb begin
    state_next      = state;
    cmd_next        = cmd;
    count_next      = count;
    base_w_next     = base_w;
    ent_next        = ent;
    ent_base_next   = ent_base;
    idx_next        = idx;
    cmp_i_next      = cmp_i;
    cp_i_next       = cp_i;
    cp_v_next       = 1'b0;
    hit_next        = hit;
    res_st_next     = res_st;
    res_addr_next   = res_addr;
    out_valid_next  = out_valid && !rsp.ready;
    out_status_next = out_status;
    out_addr_next   = out_addr;
    pop             = 1'b0;
    meta_we         = 1'b0;
    bank_free       = 1'b0;
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          pop           = 1'b1;
          cmd_next      = q_cmd;
          idx_next      = '0;
          ent_next      = '0;
          ent_base_next = '0;
          res_addr_next = '0;
          if (q_cmd.overflow) begin
            res_st_next = ST_TOO_LONG;
            state_next  = BK_DONE;
          end else if (q_cmd.kind == KIND_INSERT) begin
            if (count == CW'(MAX_ENTRIES)) begin
              res_st_next = ST_FULL;
              state_next  = BK_DONE;
            end else begin
              state_next = BK_COPY;
            end
          end else if (count == '0) begin
            res_st_next = ST_NOT_FOUND;
            state_next  = BK_DONE;
          end else begin
            state_next = BK_META;
          end
        end
      end
      BK_COPY: begin
        cp_v_next = 1'b1;
        cp_i_next = idx;
        if (idx == last_idx) begin
          state_next = BK_COPY_END;
        end else begin
          idx_next = LEN_W'(idx + LEN_W'(1));
        end
      end
      BK_COPY_END: begin
        meta_we     = 1'b1;
        count_next  = CW'(count + CW'(1));
        base_w_next = NAW'(base_w + NAW'(MAX_NAME_CHARS));
        res_st_next = ST_ADDED;
        state_next  = BK_DONE;
      end
      BK_META: begin
        idx_next   = '0;
        state_next = BK_CHK;
      end
      BK_CHK: begin
        hit_next   = meta_rdata[ADDR_W-1:0];
        cmp_i_next = '0;
        if (meta_rdata[MW-1:ADDR_W] == cmd.len) begin
          if (cmd.len > LEN_W'(1)) begin
            idx_next = LEN_W'(1);
          end
          state_next = BK_CMP;
        end else begin
          state_next = BK_NEXT;
        end
      end
      BK_CMP: begin
        cmp_i_next = idx;
        if (idx < last_idx) begin
          idx_next = LEN_W'(idx + LEN_W'(1));
        end
        if (nb_rdata != nm_rdata) begin
          state_next = BK_NEXT;
        end else if (cmp_i == last_idx) begin
          res_st_next   = ST_FOUND;
          res_addr_next = hit;
          state_next    = BK_DONE;
        end
      end
      BK_NEXT: begin
        if (CW'(CW'(ent) + CW'(1)) == count) begin
          res_st_next = ST_NOT_FOUND;
          state_next  = BK_DONE;
        end else begin
          ent_next      = EW'(ent + EW'(1));
          ent_base_next = NAW'(ent_base + NAW'(MAX_NAME_CHARS));
          state_next    = BK_META;
        end
      end
      BK_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next  = 1'b1;
          out_status_next = res_st;
          out_addr_next   = res_addr;
          bank_free       = 1'b1;
          state_next      = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      count     <= '0;
      base_w    <= '0;
      cp_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      base_w    <= base_w_next;
      cp_v      <= cp_v_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd        <= cmd_next;
    ent        <= ent_next;
    ent_base   <= ent_base_next;
    idx        <= idx_next;
    cmp_i      <= cmp_i_next;
    cp_i       <= cp_i_next;
    hit        <= hit_next;
    res_st     <= res_st_next;
    res_addr   <= res_addr_next;
    out_status <= out_status_next;
    out_addr   <= out_addr_next;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ENTRIES))
    else $error("back: entry count beyond table size");
  a_walk_in_table: assert property (@(posedge clk) disable iff (rst)
    state == BK_META |-> CW'(ent) < count)
    else $error("back: lookup walked past stored entries");
  a_addr_only_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_FOUND |-> out_addr == '0)
    else $error("back: address reported without a match");

endmodule

/* design/string_keyed_label_table.sv */
// Top level of the label symbol table: front end, queue, name buffer and back end.
//
// req carries one character beat of a label name (kind, char_code, last_char,
// label_address); only kind and label_address of the beat with last_char set
// count. rsp returns one beat per finished name: status and found_address (zero
// unless the name was found).
//
// Characters are taken one per cycle, while req.ready is high, into a two-bank name
// buffer, so the next name streams in while the back end works on the previous one.
// An insert makes one buffer read and one table write per character, then writes the
// entry header. A lookup visits entries in insertion order and compares characters
// one by one on each entry of equal length, ending on a hit or after the last entry.
// Full, too long and lookup-on-empty-table results go straight to the output.
// The lookup walk, bound by the single read port of the name store, sets the rate.
//
// rst clears the entry count, the name under collection and all handshake state;
// stored names need no clearing. When rsp stalls the result holds in the output
// register; the next name still streams in, and req drops ready only while both
// buffer banks belong to names the back end has not yet released.
module string_keyed_label_table import slt_pkg::*; #(
  parameter int MAX_ENTRIES    = 256,
  parameter int MAX_NAME_CHARS = 80
) (
  input  logic      clk,
  input  logic      rst,
  slt_req_if.sink   req,
  slt_rsp_if.source rsp
);

  localparam int BAW = $clog2(2 * MAX_NAME_CHARS);

  logic              nb_we;
  logic [BAW-1:0]    nb_waddr;
  logic [CHAR_W-1:0] nb_wdata;
  logic [BAW-1:0]    nb_raddr;
  logic [CHAR_W-1:0] nb_rdata;
  logic              push;
  cmd_t              push_cmd;
  logic              pop;
  logic              q_valid;
  cmd_t              q_cmd;
  logic              bank_free;

  // Collect characters; hand each finished name over as a command.
  slt_front #(.MAX_NAME_CHARS(MAX_NAME_CHARS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .bank_free (bank_free),
    .nb_we     (nb_we),
    .nb_waddr  (nb_waddr),
    .nb_wdata  (nb_wdata),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // Two banks of the name buffer: the front fills one while the back reads the other.
  slt_ram #(.WIDTH(CHAR_W), .DEPTH(2 * MAX_NAME_CHARS)) u_name_buf (
    .clk   (clk),
    .we    (nb_we),
    .waddr (nb_waddr),
    .wdata (nb_wdata),
    .raddr (nb_raddr),
    .rdata (nb_rdata)
  );

  // Decouple the two ends; never more than two names are in flight.
  slt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .pop_valid (q_valid),
    .pop_cmd   (q_cmd)
  );

  // Append entries or walk the table in insertion order.
  slt_back #(
    .MAX_ENTRIES    (MAX_ENTRIES),
    .MAX_NAME_CHARS (MAX_NAME_CHARS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .nb_raddr  (nb_raddr),
    .nb_rdata  (nb_rdata),
    .bank_free (bank_free),
    .rsp       (rsp)
  );

endmodule
